/* design/cgcd_pkg.sv */
// Shared types and fixed constants of the cell grid collision detector.
package cgcd_pkg;

    // Widths of the cursor registers.
    localparam int COL_W = 10;
    localparam int ROW_W = 8;
    localparam int RSC_W = 8;

    // Cursor saturation limits.
    localparam logic [COL_W-1:0] COL_MAX = '1;
    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    // Hitbox glyph codes.
    localparam logic [7:0] GLYPH_NEWLINE = 8'd10;
    localparam logic [7:0] GLYPH_EMPTY   = 8'd32;

    // Action codes.
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_GLYPH = 1'b1;

    // Classification of the glyph under the cursor.
    typedef struct packed {
        logic solid;
        logic in_grid;
    } glyph_info_t;

endpackage

/* design/cgcd_cursor.sv */
// Hitbox cursor registers and cell address generation.
module cgcd_cursor
    import cgcd_pkg::*;
#(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 64,
    parameter int ADDR_W      = 13
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              frame,
    input  logic              first_glyph,
    input  logic [7:0]        origin_x,
    input  logic [6:0]        origin_y,
    input  logic [7:0]        glyph,
    output glyph_info_t       info,
    output logic [ADDR_W-1:0] addr
);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [RSC_W-1:0] rsc_reg;
    logic [RSC_W-1:0] rsc_next;
    logic [COL_W-1:0] col_eff;
    logic [ROW_W-1:0] row_eff;
    logic [RSC_W-1:0] rsc_eff;

    // A first glyph restarts the cursor at the origin before the glyph applies.
    assign col_eff = first_glyph ? COL_W'(origin_x) : col_reg;
    assign row_eff = first_glyph ? ROW_W'(origin_y) : row_reg;
    assign rsc_eff = first_glyph ? origin_x : rsc_reg;

    // Classify the glyph and locate its cell.
    assign info.solid   = (glyph != GLYPH_NEWLINE) && (glyph != GLYPH_EMPTY);
    assign info.in_grid = (32'(col_eff) < GRID_WIDTH) && (32'(row_eff) < GRID_HEIGHT);
    assign addr         = ADDR_W'(32'(row_eff) * GRID_WIDTH + 32'(col_eff));

    // Cursor movement with saturation; a frame start returns the cursor to zero.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        rsc_next = rsc_reg;
        if (frame)
        begin
            col_next = '0;
            row_next = '0;
            rsc_next = '0;
        end
        else if (step)
        begin
            rsc_next = rsc_eff;
            if (glyph == GLYPH_NEWLINE)
            begin
                col_next = COL_W'(rsc_eff);
                row_next = (row_eff == ROW_MAX) ? ROW_MAX : row_eff + 1'b1;
            end
            else
            begin
                row_next = row_eff;
                col_next = (col_eff == COL_MAX) ? COL_MAX : col_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            rsc_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            rsc_reg <= rsc_next;
        end
    end

endmodule

/* design/cgcd_grid_mem.sv */
// Cell owner memory: one write port, one registered read port.
module cgcd_grid_mem #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/cell_grid_collision_detector.sv */
// Top level of the cell grid collision detector.
//
//  channel | direction | handshake            | words
//  in      | input     | in_valid / in_ready   | action, object_id, first_glyph, origin_*, glyph
//  out     | output    | out_valid / out_ready | collided, this_id, other_id, off_grid
//
// A solid glyph inside the grid is a read-modify-write: the cell is read in the accept
// cycle and written back in the next, so the single memory port pair sets the rate.
// Newline, space and off-grid glyphs give their word without a write-back.
// A frame start sweeps every cell, clearing it, then gives its word.
// After reset the same sweep runs before in_ready rises.
// A new word is taken only when the output register is empty or being emptied.
module cell_grid_collision_detector
    import cgcd_pkg::*;
#(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 64,
    parameter int ID_BITS     = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] object_id,
    input  logic       first_glyph,
    input  logic [7:0] origin_x,
    input  logic [6:0] origin_y,
    input  logic [7:0] glyph,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       collided,
    output logic [7:0] this_id,
    output logic [7:0] other_id,
    output logic       off_grid
);

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WB    = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [ADDR_W-1:0]  clear_idx_reg;
    logic [ADDR_W-1:0]  clear_idx_next;
    logic               report_reg;
    logic               report_next;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic [ADDR_W-1:0]  wb_addr_reg;
    logic [ADDR_W-1:0]  wb_addr_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               collided_reg;
    logic               collided_next;
    logic [7:0]         this_id_reg;
    logic [7:0]         this_id_next;
    logic [7:0]         other_id_reg;
    logic [7:0]         other_id_next;
    logic               off_grid_reg;
    logic               off_grid_next;

    logic               in_accept;
    logic               is_glyph;
    logic               start_rmw;
    logic               clear_last;
    logic [ID_BITS-1:0] id_masked;
    glyph_info_t        info;
    logic [ADDR_W-1:0]  cell_addr;
    logic [ID_BITS-1:0] rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ID_BITS-1:0] wr_data;

    // Input handshake.
    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_accept  = in_valid && in_ready;
    assign is_glyph   = (action == ACT_GLYPH);
    assign start_rmw  = in_accept && is_glyph && info.solid && info.in_grid;
    assign clear_last = (clear_idx_reg == LAST_CELL);
    assign id_masked  = ID_BITS'(object_id);

    // Cursor tracking.
    cgcd_cursor #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .ADDR_W      (ADDR_W)
    ) u_cursor (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_accept && is_glyph),
        .frame       (in_accept && !is_glyph),
        .first_glyph (first_glyph),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .glyph       (glyph),
        .info        (info),
        .addr        (cell_addr)
    );

    // The sweep and the write-back share the write port.
    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_WB);
    assign wr_addr = (state_reg == ST_CLEAR) ? clear_idx_reg : wb_addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : id_reg;

    cgcd_grid_mem #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (ID_BITS)
    ) u_grid (
        .clk     (clk),
        .rd_en   (start_rmw),
        .rd_addr (cell_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        clear_idx_next = clear_idx_reg;
        report_next    = report_reg;
        id_next        = id_reg;
        wb_addr_next   = wb_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        collided_next  = collided_reg;
        this_id_next   = this_id_reg;
        other_id_next  = other_id_reg;
        off_grid_next  = off_grid_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_idx_next = clear_idx_reg + 1'b1;
                if (clear_last)
                begin
                    clear_idx_next = '0;
                    state_next     = ST_IDLE;
                    if (report_reg)
                    begin
                        out_valid_next = 1'b1;
                        collided_next  = 1'b0;
                        this_id_next   = '0;
                        other_id_next  = '0;
                        off_grid_next  = 1'b0;
                    end
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!is_glyph)
                    begin
                        state_next  = ST_CLEAR;
                        report_next = 1'b1;
                    end
                    else if (start_rmw)
                    begin
                        state_next   = ST_WB;
                        id_next      = id_masked;
                        wb_addr_next = cell_addr;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        collided_next  = 1'b0;
                        this_id_next   = 8'(id_masked);
                        other_id_next  = '0;
                        off_grid_next  = info.solid;
                    end
                end
            end
            ST_WB:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                collided_next  = (rd_data != '0);
                this_id_next   = 8'(id_reg);
                other_id_next  = 8'(rd_data);
                off_grid_next  = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
            report_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
            report_reg    <= report_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        wb_addr_reg  <= wb_addr_next;
        collided_reg <= collided_next;
        this_id_reg  <= this_id_next;
        other_id_reg <= other_id_next;
        off_grid_reg <= off_grid_next;
    end

    assign out_valid = out_valid_reg;
    assign collided  = collided_reg;
    assign this_id   = this_id_reg;
    assign other_id  = other_id_reg;
    assign off_grid  = off_grid_reg;

    // The write-back always finds the output register empty.
    a_wb_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WB |-> !out_valid_reg)
        else $error("write-back found the output register occupied");

    // A read-modify-write is always followed by its write-back.
    a_rmw_then_wb: assert property (@(posedge clk) disable iff (!rst_n)
        start_rmw |=> state_reg == ST_WB)
        else $error("cell read not followed by write-back");

    // A new output word only follows an accept, a write-back or a sweep end.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_accept || state_reg == ST_WB
                                       || state_reg == ST_CLEAR))
        else $error("output word appeared without a source");

    // A dropped glyph never reports a collision.
    a_off_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && off_grid_reg |-> !collided_reg)
        else $error("off-grid word also reports a collision");

endmodule
